// ===== hdl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// shared types, codes and command tables for the capture sequencer
// ----------------------------------------------------------------------------
package scc_pkg;

    // job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [16:0] EXTRA_BYTES = 17'd10;

    // configuration reset values
    localparam logic [15:0] INIT_WAIT_RST  = 16'd3000;
    localparam logic [15:0] SETTLE_WAIT_RST = 16'd200;
    localparam logic [15:0] THRESHOLD_RST  = 16'd2048;

    // command and ack bytes
    localparam logic [7:0] B_LEAD_CMD = 8'h56;
    localparam logic [7:0] B_LEAD_ACK = 8'h76;
    localparam logic [7:0] B_ZERO     = 8'h00;
    localparam logic [7:0] B_ONE      = 8'h01;
    localparam logic [7:0] B_STOP_OP  = 8'h36;
    localparam logic [7:0] B_LEN_OP   = 8'h34;
    localparam logic [7:0] B_READ_OP  = 8'h32;
    localparam logic [7:0] B_RES_OP   = 8'h54;
    localparam logic [7:0] B_RES_ARG  = 8'h22;
    localparam logic [7:0] B_STOP_ARG = 8'h03;
    localparam logic [7:0] B_READ_LEN = 8'h0C;
    localparam logic [7:0] B_READ_DLY = 8'h0A;
    localparam logic [7:0] B_LEN_SIZE = 8'h04;

    // ack byte positions
    localparam logic [3:0] ACK_GEN_LAST = 4'd4;
    localparam logic [3:0] ACK_LEN_HI   = 4'd7;
    localparam logic [3:0] ACK_LEN_LO   = 4'd8;

    typedef enum logic [1:0] {
        MODE_START    = 2'd0,
        MODE_BYTE     = 2'd1,
        MODE_DMA_DONE = 2'd2,
        MODE_TICK     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_DMA  = 2'd1,
        KIND_DONE = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_INIT_WAIT   = 2'd0,
        CFG_SETTLE_WAIT = 2'd1,
        CFG_THRESHOLD   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_INIT     = 3'd0,
        PH_SETTLE   = 3'd1,
        PH_IDLE     = 3'd2,
        PH_STOP_ACK = 3'd3,
        PH_IMG_ACK  = 3'd4,
        PH_LEN_ACK  = 3'd5,
        PH_DMA      = 3'd6
    } t_phase;

    // result sequences the back end can play
    typedef enum logic [2:0] {
        SEQ_RES  = 3'd0,
        SEQ_STOP = 3'd1,
        SEQ_IMG  = 3'd2,
        SEQ_LEN  = 3'd3,
        SEQ_READ = 3'd4,
        SEQ_DONE = 3'd5,
        SEQ_ERR  = 3'd6
    } t_seq;

    typedef struct packed {
        t_seq        seq;
        logic [15:0] len;
    } t_job;

    // index of the final word of a sequence
    function automatic logic [4:0] seq_last(input t_seq seq);
        logic [4:0] r;
        unique case (seq) inside
            SEQ_READ:          r = 5'd16;
            SEQ_DONE, SEQ_ERR: r = 5'd0;
            default:           r = 5'd4;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cmd5(input logic [7:0] op, input logic [7:0] arg,
                                        input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = B_LEAD_CMD;
            3'd2:    r = op;
            3'd3:    r = B_ONE;
            3'd4:    r = arg;
            default: r = B_ZERO;
        endcase
        return r;
    endfunction

    // read command, word 0 of the read sequence is the dma start
    function automatic logic [7:0] read_byte(input logic [4:0] idx, input logic [15:0] len);
        logic [7:0] r;
        case (idx)
            5'd1:    r = B_LEAD_CMD;
            5'd3:    r = B_READ_OP;
            5'd4:    r = B_READ_LEN;
            5'd6:    r = B_READ_DLY;
            5'd13:   r = len[15:8];
            5'd14:   r = len[7:0];
            5'd16:   r = B_READ_DLY;
            default: r = B_ZERO;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] seq_byte(input t_seq seq, input logic [4:0] idx,
                                            input logic [15:0] len);
        logic [7:0] r;
        unique case (seq)
            SEQ_RES:  r = cmd5(B_RES_OP, B_RES_ARG, idx[2:0]);
            SEQ_STOP: r = cmd5(B_STOP_OP, B_STOP_ARG, idx[2:0]);
            SEQ_IMG:  r = cmd5(B_STOP_OP, B_ZERO, idx[2:0]);
            SEQ_LEN:  r = cmd5(B_LEN_OP, B_ZERO, idx[2:0]);
            SEQ_READ: r = read_byte(idx, len);
            default:  r = B_ZERO;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ack_gen_byte(input logic [3:0] pos);
        logic [7:0] r;
        case (pos)
            4'd0:    r = B_LEAD_ACK;
            4'd2:    r = B_STOP_OP;
            default: r = B_ZERO;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ack_len_byte(input logic [3:0] pos);
        logic [7:0] r;
        case (pos)
            4'd0:    r = B_LEAD_ACK;
            4'd2:    r = B_LEN_OP;
            4'd4:    r = B_LEN_SIZE;
            default: r = B_ZERO;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/serial_camera_capture_sequencer.sv =====
// ----------------------------------------------------------------------------
// serial_camera_capture_sequencer
// capture sequencer for a serial camera: init wait, resolution command,
// stop / get-image / get-length handshakes, read command and dma reporting
// ----------------------------------------------------------------------------
//
//  channel  | handshake                     | word contents
//  ---------+-------------------------------+-------------------------------------
//  in       | i_in_valid / o_in_ready       | i_mode, i_rx_byte
//  out      | o_out_valid / i_out_ready     | o_kind, o_tx_byte, o_byte_count, o_last
//  cfg      | i_cfg_we (no handshake)       | i_cfg_idx, i_cfg_data
//
// - the front takes an event word whenever the job queue has room
// - each event that produces results becomes one queued job; the back plays it
//   out at one result word per cycle while the output is not stalled, so an
//   event yields 0 to 17 result words from the output register
// - the back's single output register sets the sustained rate
// - an output stall fills the four-entry job queue, then drops o_in_ready
// - reset is synchronous, active low; config registers return to defaults
//
module serial_camera_capture_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // event words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_rx_byte,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [16:0] o_byte_count,
    output logic        o_last
);
    import scc_pkg::*;

    logic q_full, q_valid, q_pop, push, take;
    t_job push_job, head_job;

    // an event word is taken whenever the queue can hold what it may produce
    assign o_in_ready = !q_full;
    assign take       = i_in_valid && !q_full;

    // protocol phases, ack checking and config registers
    scc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_mode     (i_mode),
        .i_rx_byte  (i_rx_byte),
        .o_push     (push),
        .o_job      (push_job)
    );

    // decouples event intake from result playback
    scc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // sequence playback into the output register
    scc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_job      (head_job),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_tx_byte    (o_tx_byte),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

endmodule

// ===== hdl/scc_front.sv =====
// ----------------------------------------------------------------------------
// scc_front
// takes events, runs the protocol phases and queues result sequences
// ----------------------------------------------------------------------------
module scc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_take,
    input  logic [1:0]      i_mode,
    input  logic [7:0]      i_rx_byte,
    output logic            o_push,
    output scc_pkg::t_job   o_job
);
    import scc_pkg::*;

    logic [15:0] r_init_wait, r_settle_wait, r_threshold;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_ack_pos, n_ack_pos;
    logic        r_ack_bad, n_ack_bad;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_tick, n_tick;

    logic [16:0] tick_inc;
    logic        bad_now;
    logic [15:0] len_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_wait   <= INIT_WAIT_RST;
            r_settle_wait <= SETTLE_WAIT_RST;
            r_threshold   <= THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INIT_WAIT:   r_init_wait   <= i_cfg_data;
                CFG_SETTLE_WAIT: r_settle_wait <= i_cfg_data;
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_INIT;
            r_ack_pos <= '0;
            r_ack_bad <= 1'b0;
            r_len_hi  <= '0;
            r_len_lo  <= '0;
            r_tick    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_ack_pos <= n_ack_pos;
            r_ack_bad <= n_ack_bad;
            r_len_hi  <= n_len_hi;
            r_len_lo  <= n_len_lo;
            r_tick    <= n_tick;
        end
    end

    assign tick_inc = {1'b0, r_tick} + 17'd1;
    assign len_new  = {r_len_hi, i_rx_byte};

    always_comb begin
        n_phase   = r_phase;
        n_ack_pos = r_ack_pos;
        n_ack_bad = r_ack_bad;
        n_len_hi  = r_len_hi;
        n_len_lo  = r_len_lo;
        n_tick    = r_tick;
        o_push    = 1'b0;
        o_job.seq = SEQ_ERR;
        o_job.len = {r_len_hi, r_len_lo};
        bad_now   = 1'b0;

        if (i_take) begin
            unique case (i_mode)
                MODE_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_ack_pos = '0;
                        n_ack_bad = 1'b0;
                        n_phase   = PH_STOP_ACK;
                        o_push    = 1'b1;
                        o_job.seq = SEQ_STOP;
                    end
                end
                MODE_BYTE: begin
                    if (r_phase == PH_STOP_ACK || r_phase == PH_IMG_ACK) begin
                        bad_now = r_ack_bad || (i_rx_byte != ack_gen_byte(r_ack_pos));
                        if (r_ack_pos != ACK_GEN_LAST) begin
                            n_ack_pos = r_ack_pos + 4'd1;
                            n_ack_bad = bad_now;
                        end else begin
                            n_ack_pos = '0;
                            n_ack_bad = 1'b0;
                            o_push    = 1'b1;
                            if (bad_now) begin
                                n_phase   = PH_IDLE;
                                o_job.seq = SEQ_ERR;
                            end else if (r_phase == PH_STOP_ACK) begin
                                n_phase   = PH_IMG_ACK;
                                o_job.seq = SEQ_IMG;
                            end else begin
                                n_phase   = PH_LEN_ACK;
                                o_job.seq = SEQ_LEN;
                            end
                        end
                    end else if (r_phase == PH_LEN_ACK) begin
                        if (r_ack_pos < ACK_LEN_HI) begin
                            n_ack_bad = r_ack_bad || (i_rx_byte != ack_len_byte(r_ack_pos));
                            n_ack_pos = r_ack_pos + 4'd1;
                        end else if (r_ack_pos == ACK_LEN_HI) begin
                            n_len_hi  = i_rx_byte;
                            n_ack_pos = r_ack_pos + 4'd1;
                        end else begin
                            // final byte: length low, ack complete
                            n_len_lo  = i_rx_byte;
                            n_ack_pos = '0;
                            n_ack_bad = 1'b0;
                            o_push    = 1'b1;
                            o_job.len = len_new;
                            if (r_ack_bad) begin
                                n_phase   = PH_IDLE;
                                o_job.seq = SEQ_ERR;
                            end else if (len_new < r_threshold) begin
                                o_job.seq = SEQ_LEN;
                            end else begin
                                n_phase   = PH_DMA;
                                o_job.seq = SEQ_READ;
                            end
                        end
                    end
                end
                MODE_DMA_DONE: begin
                    if (r_phase == PH_DMA) begin
                        n_phase   = PH_IDLE;
                        o_push    = 1'b1;
                        o_job.seq = SEQ_DONE;
                    end
                end
                MODE_TICK: begin
                    if (r_phase == PH_INIT) begin
                        if (tick_inc >= {1'b0, r_init_wait}) begin
                            n_tick    = '0;
                            n_phase   = PH_SETTLE;
                            o_push    = 1'b1;
                            o_job.seq = SEQ_RES;
                        end else begin
                            n_tick = tick_inc[15:0];
                        end
                    end else if (r_phase == PH_SETTLE) begin
                        if (tick_inc >= {1'b0, r_settle_wait}) begin
                            n_tick  = '0;
                            n_phase = PH_IDLE;
                        end else begin
                            n_tick = tick_inc[15:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/scc_queue.sv =====
// ----------------------------------------------------------------------------
// scc_queue
// small job fifo between front and back
// ----------------------------------------------------------------------------
module scc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scc_pkg::t_job   i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output scc_pkg::t_job   o_job
);
    import scc_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/scc_back.sv =====
// ----------------------------------------------------------------------------
// scc_back
// plays queued sequences out one result word per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module scc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  scc_pkg::t_job   i_q_job,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_tx_byte,
    output logic [16:0]     o_byte_count,
    output logic            o_last
);
    import scc_pkg::*;

    logic [4:0]  r_idx;
    logic        r_valid;
    t_kind       r_kind, w_kind;
    logic [7:0]  r_tx;
    logic [16:0] r_count;
    logic        r_last;
    logic        load, is_last;

    assign load    = (!r_valid || i_out_ready) && i_q_valid;
    assign is_last = (r_idx == seq_last(i_q_job.seq));
    assign o_q_pop = load && is_last;

    always_comb begin
        unique case (i_q_job.seq)
            SEQ_DONE: w_kind = KIND_DONE;
            SEQ_ERR:  w_kind = KIND_ERR;
            SEQ_READ: w_kind = (r_idx == '0) ? KIND_DMA : KIND_TX;
            default:  w_kind = KIND_TX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? '0 : r_idx + 5'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= w_kind;
            r_tx    <= (w_kind == KIND_TX) ? seq_byte(i_q_job.seq, r_idx, i_q_job.len) : '0;
            r_count <= (w_kind == KIND_DMA || w_kind == KIND_DONE)
                       ? {1'b0, i_q_job.len} + EXTRA_BYTES : '0;
            r_last  <= is_last;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_kind       = r_kind;
    assign o_tx_byte    = r_tx;
    assign o_byte_count = r_count;
    assign o_last       = r_last;

endmodule

// ===== hdl/scc_checker.sv =====
// ----------------------------------------------------------------------------
// scc_checker
// port-level checks on the capture sequencer
// ----------------------------------------------------------------------------
module scc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_tx_byte,
    input logic [16:0] o_byte_count,
    input logic        o_last
);
    import scc_pkg::*;

    // output word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_tx_byte) && $stable(o_byte_count) && $stable(o_last))
        else $error("output word changed while stalled");

    // nothing shows right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // transmit words carry no count
    a_tx_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_TX |-> o_byte_count == '0)
        else $error("transmit word with nonzero count");

    // done and mismatch always end their event
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_DONE || o_kind == KIND_ERR) |-> o_last)
        else $error("done or mismatch word not last");

    // dma start is followed by the read command, never last
    a_dma_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DMA |-> !o_last && o_byte_count >= EXTRA_BYTES)
        else $error("bad dma start word");

endmodule

bind serial_camera_capture_sequencer scc_checker u_scc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_tx_byte    (o_tx_byte),
    .o_byte_count (o_byte_count),
    .o_last       (o_last)
);
